// ----- hdl/xs1024_pkg.sv -----
// Package: payload structs, command codes and the generator constants.
`default_nettype none
package xs1024_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned PTR_W    = 4;
  localparam int unsigned NUM_WORDS = 16;

  localparam logic [63:0] XS_MULT = 64'h1066_89D4_5497_FDB5;
  localparam int unsigned SHL_A = 31;
  localparam int unsigned SHR_B = 11;
  localparam int unsigned SHR_C = 30;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  seed_index;
    logic [63:0] seed_value;
    logic        last_of_request;
  } req_t;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       last_out;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/xorshift1024_star_byte_generator.sv -----
// Top level: xorshift1024* byte generator built around a 16 x 64 state memory.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_ready | cmd, seed_index, seed_value,
//          |           |                       | last_of_request
//  rsp     | out       | rsp_valid / rsp_ready | random_byte, last_out
//
// One item per cycle while rsp is not stalled. The state memory is read at the
// accepting edge (registered, two read ports); the update stage then does the
// xorshift update, writes the word back and loads the output register that
// drives rsp.
// A write made at the same edge as the next item's memory read is forwarded
// into that item's update, so back-to-back items never wait on each other.
// Reset (rst, synchronous) clears the word pointer, the pipeline valids and
// one valid flag per state word; a word never written reads as zero.
// A stalled rsp holds the update stage; req_ready drops only then.
`default_nettype none
module xorshift1024_star_byte_generator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire xs1024_pkg::req_t  req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output xs1024_pkg::rsp_t       rsp
);

  localparam int unsigned PW = xs1024_pkg::PTR_W;
  localparam int unsigned WW = xs1024_pkg::WORD_W;

  // state memory, one valid flag per word stands in for the reset clear
  logic [WW-1:0] mem [xs1024_pkg::NUM_WORDS];
  logic [xs1024_pkg::NUM_WORDS-1:0] wvld;

  logic [PW-1:0] ptr;

  logic          req_fire;
  logic [PW-1:0] rd_a0;
  logic [PW-1:0] rd_a1;

  // read stage outputs (registered memory data)
  logic [WW-1:0] rd0;
  logic [WW-1:0] rd1;
  logic          rd0_v;
  logic          rd1_v;

  // update stage item
  logic          b_valid;
  logic          b_cmd;
  logic [PW-1:0] b_a0;
  logic [PW-1:0] b_a1;
  logic [PW-1:0] b_idx;
  logic [WW-1:0] b_val;
  logic          b_last;
  logic          b_fire;

  // most recent write, for forwarding
  logic          wq_valid;
  logic [PW-1:0] wq_addr;
  logic [WW-1:0] wq_data;

  logic [WW-1:0] s0;
  logic [WW-1:0] s1;
  logic [WW-1:0] s1a;
  logic [WW-1:0] s1b;
  logic [WW-1:0] s0a;
  logic [WW-1:0] w;
  logic [15:0]   prod;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  assign req_fire = req_valid && req_ready;
  assign rd_a0    = ptr;
  assign rd_a1    = ptr + PW'(1);

  // update stage moves unless its byte would overwrite a waiting result
  assign b_fire    = b_valid &&
                     ((b_cmd == xs1024_pkg::CMD_LOAD) || !rsp_valid || rsp_ready);
  assign req_ready = !b_valid || b_fire;

  // word pointer: loads rewind it, generates step it
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (req_fire) begin
      if (req.cmd == xs1024_pkg::CMD_LOAD) begin
        ptr <= '0;
      end else begin
        ptr <= rd_a1;
      end
    end
  end

  // memory read ports, enabled on acceptance
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd0 <= mem[rd_a0];
      rd1 <= mem[rd_a1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd0_v <= 1'b0;
      rd1_v <= 1'b0;
    end else if (req_fire) begin
      rd0_v <= wvld[rd_a0];
      rd1_v <= wvld[rd_a1];
    end
  end

  // update stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (req_fire) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      b_cmd  <= req.cmd;
      b_a0   <= rd_a0;
      b_a1   <= rd_a1;
      b_idx  <= req.seed_index;
      b_val  <= req.seed_value;
      b_last <= req.last_of_request;
    end
  end

  // operands with forwarding of the write made at the read edge
  always_comb begin
    if (wq_valid && (wq_addr == b_a0)) begin
      s0 = wq_data;
    end else begin
      s0 = rd0_v ? rd0 : '0;
    end
    if (wq_valid && (wq_addr == b_a1)) begin
      s1 = wq_data;
    end else begin
      s1 = rd1_v ? rd1 : '0;
    end
    s1a  = s1 ^ (s1 << xs1024_pkg::SHL_A);
    s1b  = s1a ^ (s1a >> xs1024_pkg::SHR_B);
    s0a  = s0 ^ (s0 >> xs1024_pkg::SHR_C);
    w    = s0a ^ s1b;
    // only the low byte of the product is kept, so low bytes suffice
    prod = {8'd0, w[7:0]} * {8'd0, xs1024_pkg::XS_MULT[7:0]};
  end

  // single write port: loads write their word, generates the new word
  assign wr_en   = b_fire;
  assign wr_addr = (b_cmd == xs1024_pkg::CMD_LOAD) ? b_idx : b_a1;
  assign wr_data = (b_cmd == xs1024_pkg::CMD_LOAD) ? b_val : w;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvld     <= '0;
      wq_valid <= 1'b0;
    end else if (wr_en) begin
      wvld[wr_addr] <= 1'b1;
      wq_valid      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wq_addr <= wr_addr;
      wq_data <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (b_fire && (b_cmd == xs1024_pkg::CMD_GEN)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && (b_cmd == xs1024_pkg::CMD_GEN)) begin
      rsp.random_byte <= prod[7:0];
      rsp.last_out    <= b_last;
    end
  end

endmodule
`default_nettype wire
